[src/sgdm_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths, register indexes and saturation helper for the
// SGD momentum update block. No dependencies.
package sgdm_pkg;

	localparam int DATA_W     = 32;
	localparam int SLOT_W     = 10;
	localparam int COEF_W     = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int SLOTS_DEF  = 1024;
	localparam int FRAC_DEF   = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_LR    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MOM   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DAMP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NEST  = 3'd4;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [COEF_W-1:0]        coef_t;
	typedef logic [SLOT_W-1:0]        slot_t;

	localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
	localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

	function automatic data_t sat32(input logic signed [63:0] x);
		data_t r;
		if (x > SAT_MAX) begin
			r = data_t'(SAT_MAX);
		end else if (x < SAT_MIN) begin
			r = data_t'(SAT_MIN);
		end else begin
			r = data_t'(x);
		end
		return r;
	endfunction

endpackage

[src/sgdm_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sgdm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/sgd_momentum_update.sv]
`timescale 1ns / 1ps
// SGD update with momentum, dampening, Nesterov look-ahead and weight decay.
// Depends on sgdm_pkg and sgdm_ram (momentum store and valid marks).
//
// One item per cycle is accepted unless the output stalls; results are presented
// in order. The pipeline has eight compute stages (one multiply or one
// add-and-saturate each, save stage four, which holds the momentum multiply and
// its add) and an output register; the momentum buffer recurrence closes in
// stage four, where values not yet visible in the store are forwarded from the
// four stages behind it, so repeated slots keep full rate. The output register
// lets the pipeline keep taking items while a result waits, as long as stage
// eight is free. After reset, item_ready stays low while a clearing pass zeroes
// the valid marks; configuration writes are taken throughout.
module sgd_momentum_update #(
	parameter int SLOTS     = sgdm_pkg::SLOTS_DEF,
	parameter int FRAC_BITS = sgdm_pkg::FRAC_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [sgdm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sgdm_pkg::COEF_W-1:0]        cfg_data,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  logic [sgdm_pkg::SLOT_W-1:0]        slot,
	input  logic signed [sgdm_pkg::DATA_W-1:0] param_value,
	input  logic signed [sgdm_pkg::DATA_W-1:0] grad_value,
	input  logic                               grad_present,
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic signed [sgdm_pkg::DATA_W-1:0] new_param,
	output logic signed [sgdm_pkg::DATA_W-1:0] momentum_out
);
	import sgdm_pkg::*;

	localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CS_W   = COEF_W + 1;
	localparam int DAMP_W = (FRAC_BITS + 2 > CS_W) ? FRAC_BITS + 2 : CS_W;
	localparam int PC_W   = DATA_W + CS_W;
	localparam int PD_W   = DATA_W + DAMP_W;

	typedef logic [ADDR_W-1:0] addr_t;

	// configuration
	coef_t lr_q, mom_q, damp_q, decay_q;
	logic  nest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q    <= '0;
			mom_q   <= '0;
			damp_q  <= '0;
			decay_q <= '0;
			nest_q  <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_LR:    lr_q    <= cfg_data;
				CFG_MOM:   mom_q   <= cfg_data;
				CFG_DAMP:  damp_q  <= cfg_data;
				CFG_DECAY: decay_q <= cfg_data;
				CFG_NEST:  nest_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic                     mom_on;
	logic signed [CS_W-1:0]   wd_c, m_c, lr_c;
	logic signed [DAMP_W-1:0] damp_c;

	assign mom_on = (mom_q != '0);
	assign wd_c   = signed'({1'b0, decay_q});
	assign m_c    = signed'({1'b0, mom_q});
	assign lr_c   = signed'(CS_W'(0) - {1'b0, lr_q});
	assign damp_c = signed'(DAMP_W'(1 << FRAC_BITS) - DAMP_W'(damp_q));

	// clearing pass for the valid marks
	logic  clr_q;
	addr_t clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			if (clr_cnt_q == addr_t'(SLOTS - 1)) begin
				clr_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + addr_t'(1);
		end
	end

	// pipeline control
	logic en, take;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	assign en         = ~v_s8 | ~v_s9 | result_ready;
	assign item_ready = en & ~clr_q;
	assign take       = item_valid & item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (en) begin
				v_s1 <= take;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
				v_s5 <= v_s4;
				v_s6 <= v_s5;
				v_s7 <= v_s6;
				v_s8 <= v_s7;
			end
			if (en && v_s8) begin
				v_s9 <= 1'b1;
			end else if (result_ready) begin
				v_s9 <= 1'b0;
			end
		end
	end

	// stores
	logic  in_range;
	addr_t rd_addr, addr_s4;
	data_t old_rd;
	logic  vld_rd;
	logic  st_we, vld_we, vld_wd;
	addr_t vld_waddr;
	data_t buf_c;
	logic  wr_s4;

	assign in_range  = (32'(slot) < 32'(SLOTS));
	assign rd_addr   = addr_t'(slot);
	assign st_we     = en & v_s4 & wr_s4;
	assign vld_we    = clr_q | st_we;
	assign vld_waddr = clr_q ? clr_cnt_q : addr_s4;
	assign vld_wd    = ~clr_q;

	sgdm_ram #(
		.WIDTH (DATA_W),
		.DEPTH (SLOTS)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (addr_s4),
		.wdata (buf_c),
		.re    (en),
		.raddr (rd_addr),
		.rdata (old_rd)
	);

	sgdm_ram #(
		.WIDTH (1),
		.DEPTH (SLOTS)
	) u_valid (
		.clk   (clk),
		.we    (vld_we),
		.waddr (vld_waddr),
		.wdata (vld_wd),
		.re    (en),
		.raddr (rd_addr),
		.rdata (vld_rd)
	);

	// payload registers
	slot_t slot_s1, slot_s2, slot_s3, slot_s4, slot_s5, slot_s6, slot_s7, slot_s8;
	data_t p_s1, p_s2, p_s3, p_s4, p_s5, p_s6, p_s7, p_s8;
	data_t g_s1, g_s2;
	logic  pres_s1, pres_s2, pres_s3, pres_s4, pres_s5, pres_s6, pres_s7, pres_s8;
	logic  inr_s1, ok_s2, ok_s3, ok_s4;
	logic  wr_s1, wr_s2, wr_s3, wr_s5, wr_s6, wr_s7, wr_s8;
	data_t old_s2, old_s3, old_s4;
	data_t d_s3, d_s4, d_s5, d_s6, d2_s7;
	data_t buf_s5, buf_s6, buf_s7, buf_s8;
	data_t np_s9, mo_s9;

	logic signed [PC_W-1:0] prodwd_s2, prodn_s6, prodlr_s8;
	logic signed [PD_W-1:0] proddd_s4;

	logic signed [PC_W-1:0] prod_wd, prod_mo, prod_n, prod_lr;
	logic signed [PD_W-1:0] prod_dd;
	data_t                  d_c, old_eff, d2_c, np_c, mo_c;
	logic                   hit5, hit6, hit7, hit8, first;

	// s1: weight decay product
	assign prod_wd = p_s1 * wd_c;
	// s2: gradient plus decay
	assign d_c = sat32(64'(g_s2) + 64'(prodwd_s2 >>> FRAC_BITS));
	// s3: dampened gradient product
	assign prod_dd = d_s3 * damp_c;
	// s4: buffer recurrence with forwarding
	assign hit5    = v_s5 & wr_s5 & (slot_s5 == slot_s4);
	assign hit6    = v_s6 & wr_s6 & (slot_s6 == slot_s4);
	assign hit7    = v_s7 & wr_s7 & (slot_s7 == slot_s4);
	assign hit8    = v_s8 & wr_s8 & (slot_s8 == slot_s4);
	assign old_eff = hit5 ? buf_s5 :
	                 (hit6 ? buf_s6 : (hit7 ? buf_s7 : (hit8 ? buf_s8 : old_s4)));
	assign first   = ~(hit5 | hit6 | hit7 | hit8 | ok_s4);
	assign prod_mo = old_eff * m_c;
	assign buf_c   = first ? d_s4
	                       : sat32(64'(prod_mo >>> FRAC_BITS) + 64'(proddd_s4 >>> FRAC_BITS));
	assign addr_s4 = addr_t'(slot_s4);
	// s5: look-ahead product
	assign prod_n = buf_s5 * m_c;
	// s6: step direction
	always_comb begin
		if (!mom_on) begin
			d2_c = d_s6;
		end else if (nest_q) begin
			d2_c = sat32(64'(d_s6) + 64'(prodn_s6 >>> FRAC_BITS));
		end else begin
			d2_c = buf_s6;
		end
	end
	// s7: learning rate product
	assign prod_lr = d2_s7 * lr_c;
	// s8: parameter update
	assign np_c = pres_s8 ? sat32(64'(p_s8) + 64'(prodlr_s8 >>> FRAC_BITS)) : p_s8;
	assign mo_c = (pres_s8 && mom_on) ? buf_s8 : '0;

	always_ff @(posedge clk) begin
		if (en) begin
			slot_s1 <= slot;
			p_s1    <= param_value;
			g_s1    <= grad_value;
			pres_s1 <= grad_present;
			inr_s1  <= in_range;
			wr_s1   <= grad_present & mom_on & in_range;

			slot_s2   <= slot_s1;
			p_s2      <= p_s1;
			g_s2      <= g_s1;
			pres_s2   <= pres_s1;
			wr_s2     <= wr_s1;
			ok_s2     <= inr_s1 & vld_rd;
			old_s2    <= old_rd;
			prodwd_s2 <= prod_wd;

			slot_s3 <= slot_s2;
			p_s3    <= p_s2;
			pres_s3 <= pres_s2;
			wr_s3   <= wr_s2;
			ok_s3   <= ok_s2;
			old_s3  <= old_s2;
			d_s3    <= d_c;

			slot_s4   <= slot_s3;
			p_s4      <= p_s3;
			pres_s4   <= pres_s3;
			wr_s4     <= wr_s3;
			ok_s4     <= ok_s3;
			old_s4    <= old_s3;
			d_s4      <= d_s3;
			proddd_s4 <= prod_dd;

			slot_s5 <= slot_s4;
			p_s5    <= p_s4;
			pres_s5 <= pres_s4;
			wr_s5   <= wr_s4;
			d_s5    <= d_s4;
			buf_s5  <= buf_c;

			slot_s6  <= slot_s5;
			p_s6     <= p_s5;
			pres_s6  <= pres_s5;
			wr_s6    <= wr_s5;
			d_s6     <= d_s5;
			buf_s6   <= buf_s5;
			prodn_s6 <= prod_n;

			slot_s7 <= slot_s6;
			p_s7    <= p_s6;
			pres_s7 <= pres_s6;
			wr_s7   <= wr_s6;
			buf_s7  <= buf_s6;
			d2_s7   <= d2_c;

			slot_s8   <= slot_s7;
			p_s8      <= p_s7;
			pres_s8   <= pres_s7;
			wr_s8     <= wr_s7;
			buf_s8    <= buf_s7;
			prodlr_s8 <= prod_lr;
		end
		if (en && v_s8) begin
			np_s9 <= np_c;
			mo_s9 <= mo_c;
		end
	end

	assign result_valid = v_s9;
	assign new_param    = np_s9;
	assign momentum_out = mo_s9;

endmodule
